>>> rtl/sdc_pkg.sv
package sdc_pkg;

  // generator and product widths
  localparam int GenW       = 31;
  localparam int FoldInW    = 47;
  localparam int OpAW       = 34;
  localparam int OpBW       = 17;
  localparam int ProdW      = OpAW + OpBW;
  localparam int NoiseShift = 39;
  localparam int NoiseW     = ProdW - NoiseShift;
  localparam int ScaleW     = 16;
  localparam int FoldCW     = 8;

  // generator moduli and multipliers
  localparam logic [GenW-1:0]   ModOne = 31'd2147483563;
  localparam logic [GenW-1:0]   ModTwo = 31'd2147483399;
  localparam logic [OpBW-1:0]   MulOne = 17'd40014;
  localparam logic [OpBW-1:0]   MulTwo = 17'd40692;

  // 2^31 mod each modulus, used to fold the upper product bits
  localparam logic [FoldCW-1:0] FoldOne = 8'd85;
  localparam logic [FoldCW-1:0] FoldTwo = 8'd249;

  // 2z - ModOne written in terms of s = g1 + g2, for both wrap cases
  localparam logic [OpAW-1:0]   ThreeModOne   = 34'd6442450689;
  localparam logic [OpAW-1:0]   ModOnePlusTwo = 34'd2147483565;

  // reset values
  localparam logic [GenW-1:0]   GenOneReset = 31'd55555;
  localparam logic [GenW-1:0]   GenTwoReset = 31'd99999;
  localparam logic [ScaleW-1:0] ScaleReset  = 16'd256;

endpackage

>>> rtl/sdc_mod_fold.sv
module sdc_mod_fold (
  input  logic [sdc_pkg::FoldInW-1:0] prod_i,
  input  logic                        sel_two_i,
  output logic [sdc_pkg::GenW-1:0]    res_o
);
  import sdc_pkg::*;

  logic [FoldInW-GenW-1:0]        hi;
  logic [GenW-1:0]                lo;
  logic [FoldCW-1:0]              fold_c;
  logic [GenW-1:0]                modulus;
  logic [FoldInW-GenW+FoldCW-1:0] hi_c;
  logic [GenW:0]                  sum;

  assign hi      = prod_i[FoldInW-1:GenW];
  assign lo      = prod_i[GenW-1:0];
  assign fold_c  = sel_two_i ? FoldTwo : FoldOne;
  assign modulus = sel_two_i ? ModTwo : ModOne;
  assign hi_c    = hi * fold_c;
  // hi * 2^31 == hi * fold_c, and the sum stays below twice the modulus
  assign sum     = {1'b0, lo} + (GenW+1)'(hi_c);

  always_comb begin
    if (sum >= {1'b0, modulus}) begin
      res_o = GenW'(sum - {1'b0, modulus});
    end else begin
      res_o = sum[GenW-1:0];
    end
  end

endmodule

>>> rtl/sample_dither_combined_lcg.sv
// each sample runs through the steps Mul1, Red1, Mul2, Red2, Comb, MulN and Out
// a new sample is taken only in the idle step, using the single shared multiplier
//   used three times per sample (two generator steps and the noise scaling)
// a waiting output beat holds the sequencer in its last step until taken
// reset (async, active low): generators at 55555 and 99999, scale at 256,
//   no beat pending
module sample_dither_combined_lcg #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                       clipped_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sdc_pkg::ScaleW-1:0] dither_scale_i
);
  import sdc_pkg::*;

  // sum width covers sample plus noise without overflow
  localparam int SumW = ((SAMPLE_BITS > NoiseW) ? SAMPLE_BITS : NoiseW) + 1;

  // sequencer steps
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul1 = 3'd1;
  localparam logic [2:0] StRed1 = 3'd2;
  localparam logic [2:0] StMul2 = 3'd3;
  localparam logic [2:0] StRed2 = 3'd4;
  localparam logic [2:0] StComb = 3'd5;
  localparam logic [2:0] StMulN = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  logic [2:0]                    state_q, state_d;
  logic [GenW-1:0]               g1_q, g1_d;
  logic [GenW-1:0]               g2_q, g2_d;
  logic [ScaleW-1:0]             scale_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [ProdW-1:0]       prod_q;
  logic signed [OpAW-1:0]        diff_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_clip_q;

  logic signed [OpAW-1:0]        mul_a;
  logic signed [OpBW-1:0]        mul_b;
  logic signed [ProdW-1:0]       mul_p;
  logic [GenW-1:0]               fold_res;
  logic [GenW:0]                 gen_sum;
  logic [OpAW-1:0]               gen_sum2;
  logic signed [OpAW-1:0]        diff_d;
  logic signed [NoiseW-1:0]      noise;
  logic signed [SumW-1:0]        dith_sum;
  logic                          fits;
  logic signed [SAMPLE_BITS-1:0] sat_val;
  logic                          in_beat;
  logic                          out_free;

  assign in_ready_o   = (state_q == StIdle);
  assign in_beat      = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign clipped_o    = out_clip_q;

  // shared multiplier: generator steps, then noise scaling
  always_comb begin
    case (state_q)
      StMul1: begin
        mul_a = $signed({{(OpAW-GenW){1'b0}}, g1_q});
        mul_b = $signed(MulOne);
      end
      StMul2: begin
        mul_a = $signed({{(OpAW-GenW){1'b0}}, g2_q});
        mul_b = $signed(MulTwo);
      end
      default: begin
        mul_a = diff_q;
        mul_b = $signed({1'b0, scale_q});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // modular fold of the generator product
  sdc_mod_fold u_fold (
    .prod_i    (prod_q[FoldInW-1:0]),
    .sel_two_i (state_q == StRed2),
    .res_o     (fold_res)
  );

  // combination: z = s - ModOne, wrapped when z < 1, then 2z - ModOne
  assign gen_sum  = {1'b0, g1_q} + {1'b0, g2_q};
  assign gen_sum2 = {1'b0, gen_sum, 1'b0};
  always_comb begin
    if (gen_sum > {1'b0, ModOne}) begin
      diff_d = $signed(gen_sum2 - ThreeModOne);
    end else begin
      diff_d = $signed(gen_sum2 - ModOnePlusTwo);
    end
  end

  // arithmetic shift gives the floor of the scaled noise
  assign noise    = prod_q[ProdW-1:NoiseShift];
  assign dith_sum = $signed({{(SumW-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q})
                  + $signed({{(SumW-NoiseW){noise[NoiseW-1]}}, noise});
  // no overflow when every bit above the sample's sign matches it
  assign fits     = (dith_sum[SumW-1:SAMPLE_BITS-1] == {(SumW-SAMPLE_BITS+1){1'b0}})
                 || (dith_sum[SumW-1:SAMPLE_BITS-1] == {(SumW-SAMPLE_BITS+1){1'b1}});
  assign sat_val  = dith_sum[SumW-1] ? $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}})
                                     : $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});

  // sequencer
  always_comb begin
    state_d = state_q;
    g1_d    = g1_q;
    g2_d    = g2_q;
    case (state_q)
      StIdle: if (in_beat) state_d = StMul1;
      StMul1: state_d = StRed1;
      StRed1: begin
        g1_d    = fold_res;
        state_d = StMul2;
      end
      StMul2: state_d = StRed2;
      StRed2: begin
        g2_d    = fold_res;
        state_d = StComb;
      end
      StComb: state_d = StMulN;
      StMulN: state_d = StOut;
      StOut:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      g1_q        <= GenOneReset;
      g2_q        <= GenTwoReset;
      scale_q     <= ScaleReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      g1_q    <= g1_d;
      g2_q    <= g2_d;
      if (cfg_valid_i) begin
        scale_q <= dither_scale_i;
      end
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      sample_q <= sample_in_i;
    end
    if (state_q == StMul1 || state_q == StMul2 || state_q == StMulN) begin
      prod_q <= mul_p;
    end
    if (state_q == StComb) begin
      diff_q <= diff_d;
    end
    if (state_q == StOut && out_free) begin
      out_sample_q <= fits ? dith_sum[SAMPLE_BITS-1:0] : sat_val;
      out_clip_q   <= !fits;
    end
  end

endmodule

>>> rtl/sdc_checker.sv
module sdc_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] sample_out_o,
  input logic                          clipped_o
);

  // busy right after an input beat
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a sample is in work");

  // a fresh result leaves the sequencer ready for the next sample
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result shown while sequencer still busy");

  // a clipped result sits at one of the rails
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |->
      (sample_out_o == $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}}))
      || (sample_out_o == $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}})))
    else $error("clipped flag without a saturated value");

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(sample_out_o) && $stable(clipped_o)))
    else $error("stalled output beat changed");

endmodule

bind sample_dither_combined_lcg sdc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sdc_checker (.*);
